>>> sv/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned SPQ_DEPTH = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } spq_in_t;

  typedef struct packed {
    logic               found;
    logic [4:0]         position;
    logic               dropped;
    logic               head_valid;
    logic signed [31:0] head_value;
    logic [4:0]         entry_count;
  } spq_out_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic signed [31:0] value;
  } spq_cell_ctl_t;

endpackage
`default_nettype wire

>>> sv/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted store: compares its entry against the broadcast
// value and shifts right on insert or left on remove.
// ----------------------------------------------------------------------------
module spq_cell (
  input  wire                    clk_i,
  input  spq_pkg::spq_cell_ctl_t ctl_i,
  input  wire                    occ_i,
  input  wire                    left_lt_i,
  input  wire signed [31:0]      left_val_i,
  input  wire signed [31:0]      right_val_i,
  output logic signed [31:0]     val_o,
  output logic                   lt_o,
  output logic                   eq_o
);
  import spq_pkg::*;

  logic signed [31:0] val_q, val_d;

  assign lt_o  = occ_i && (val_q < ctl_i.value);
  assign eq_o  = occ_i && (val_q == ctl_i.value);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins && !lt_o) begin
      // first cell not below the value takes it, the rest move right
      val_d = left_lt_i ? ctl_i.value : left_val_i;
    end else if (ctl_i.rem && !lt_o) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
`default_nettype wire

>>> sv/spq_enc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_enc
// Turns the thermometer of "entry below value" flags into a count, which is
// both the insert slot and the index of the first equal entry.
// ----------------------------------------------------------------------------
module spq_enc #(
  parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire [DEPTH-1:0] lt_i,
  output logic [CW-1:0]   count_o
);
  import spq_pkg::*;

  logic [DEPTH:0] therm;

  assign therm = {1'b0, lt_i};

  always_comb begin
    count_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      // last set flag marks the boundary
      if (therm[i] && !therm[i+1]) begin
        count_o = count_o | CW'(i + 1);
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/sorted_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded ascending store of signed values with insert, remove and find.
// ----------------------------------------------------------------------------
// One command beat is taken per cycle and its result beat appears in the
// output register on the next cycle. All DEPTH cells compare their entry
// with the command value in parallel and shift in the same cycle, so the
// sustained rate is one beat per cycle; a new beat is taken whenever the
// output register is empty or is being drained in that cycle. Position and
// entry count are reported in 5 bits.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  spq_pkg::spq_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic               accept;
  logic [CW-1:0]      count_q, count_d;
  logic               out_valid_q;
  spq_out_t           out_q, out_d;
  logic [DEPTH-1:0]   occ, lt, eq;
  logic signed [31:0] val [DEPTH];
  logic [CW-1:0]      lt_count;
  logic               full, hit;
  spq_cell_ctl_t      ctl;
  logic               is_ins, is_rem, is_find;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign full    = (count_q == CW'(DEPTH));
  assign hit     = |eq;
  assign is_ins  = (in_data_i.command == CMD_INSERT);
  assign is_rem  = (in_data_i.command == CMD_REMOVE);
  assign is_find = (in_data_i.command == CMD_FIND);

  assign ctl.ins   = accept && is_ins && !full;
  assign ctl.rem   = accept && is_rem && hit;
  assign ctl.value = in_data_i.value;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign occ[g] = (CW'(g) < count_q);
    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (occ[g]),
      .left_lt_i   ((g == 0) ? 1'b1 : lt[(g == 0) ? 0 : g - 1]),
      .left_val_i  ((g == 0) ? in_data_i.value : val[(g == 0) ? 0 : g - 1]),
      .right_val_i ((g == DEPTH - 1) ? in_data_i.value
                                     : val[(g == DEPTH - 1) ? g : g + 1]),
      .val_o       (val[g]),
      .lt_o        (lt[g]),
      .eq_o        (eq[g])
    );
  end

  spq_enc #(.DEPTH(DEPTH)) u_enc (
    .lt_i    (lt),
    .count_o (lt_count)
  );

  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + CW'(1);
    end else if (ctl.rem) begin
      count_d = count_q - CW'(1);
    end

    out_d             = '0;
    out_d.entry_count = 5'(count_d);
    out_d.head_valid  = (count_d != '0);
    if (count_d != '0) begin
      priority if (ctl.ins && !lt[0]) begin
        out_d.head_value = in_data_i.value;
      end else if (ctl.rem && !lt[0]) begin
        out_d.head_value = val[1];
      end else begin
        out_d.head_value = val[0];
      end
    end
    if (is_ins) begin
      if (full) begin
        out_d.dropped = 1'b1;
      end else begin
        out_d.found    = 1'b1;
        out_d.position = 5'(lt_count);
      end
    end else if ((is_rem || is_find) && hit) begin
      out_d.found    = 1'b1;
      out_d.position = 5'(lt_count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((lt >> 1) & ~lt) == '0)
    else $error("stored entries out of order");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_ins && !full |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not add an entry");

  a_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.dropped && out_q.found))
    else $error("result both dropped and found");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.head_valid == (count_q != '0))
    else $error("head valid disagrees with entry count");
`endif

endmodule
`default_nettype wire

>>> tb/sv/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Shadow model and scoreboard for the sorted priority queue.
// ----------------------------------------------------------------------------
// Watches both channels. Every accepted command beat is applied to a shadow
// copy of the sorted store and the result it should produce is queued; every
// accepted result beat is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module spq_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  spq_pkg::spq_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  spq_pkg::spq_out_t out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       drops_o,
  output int unsigned       hits_o
);
  import spq_pkg::*;

  logic signed [31:0] shadow_store [SPQ_DEPTH];
  int unsigned        shadow_fill;
  spq_out_t           expected_q [$];
  int unsigned        fails;
  int unsigned        checked;
  int unsigned        drops;
  int unsigned        hits;

  function automatic spq_out_t apply_command(input spq_in_t beat);
    spq_out_t    res;
    int unsigned slot;
    logic        hit;
    res   = '0;
    slot  = shadow_fill;
    hit   = 1'b0;
    case (beat.command)
      CMD_INSERT: begin
        if (shadow_fill >= SPQ_DEPTH) begin
          res.dropped = 1'b1;
        end else begin
          // new value goes ahead of any equal entries
          for (int i = 0; i < shadow_fill; i++) begin
            if (!hit && shadow_store[i] >= beat.value) begin
              slot = i;
              hit  = 1'b1;
            end
          end
          for (int i = shadow_fill; i > slot; i--) begin
            shadow_store[i] = shadow_store[i-1];
          end
          shadow_store[slot] = beat.value;
          shadow_fill++;
          res.found    = 1'b1;
          res.position = slot[4:0];
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        for (int i = 0; i < shadow_fill; i++) begin
          if (!hit && shadow_store[i] == beat.value) begin
            slot = i;
            hit  = 1'b1;
          end
        end
        if (hit) begin
          res.found    = 1'b1;
          res.position = slot[4:0];
          if (beat.command == CMD_REMOVE) begin
            for (int i = slot; i + 1 < shadow_fill; i++) begin
              shadow_store[i] = shadow_store[i+1];
            end
            shadow_fill--;
          end
        end
      end
      default: begin
      end
    endcase
    res.head_valid  = (shadow_fill != 0);
    res.head_value  = (shadow_fill != 0) ? shadow_store[0] : '0;
    res.entry_count = shadow_fill[4:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] expv,
                             input logic signed [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spq_out_t exp_beat;
    if (!rst_ni) begin
      shadow_fill = 0;
      expected_q.delete();
      fails   = 0;
      checked = 0;
      drops   = 0;
      hits    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no command outstanding");
          fails++;
        end else begin
          exp_beat = expected_q.pop_front();
          check_field("found", exp_beat.found, out_data_i.found);
          check_field("position", exp_beat.position, out_data_i.position);
          check_field("dropped", exp_beat.dropped, out_data_i.dropped);
          check_field("head_valid", exp_beat.head_valid, out_data_i.head_valid);
          check_field("head_value", exp_beat.head_value, out_data_i.head_value);
          check_field("entry_count", exp_beat.entry_count, out_data_i.entry_count);
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        exp_beat = apply_command(in_data_i);
        if (exp_beat.dropped) drops++;
        if (exp_beat.found && in_data_i.command != CMD_INSERT) hits++;
        expected_q.push_back(exp_beat);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    checked_o    <= checked;
    drops_o      <= drops;
    hits_o       <= hits;
  end

endmodule

>>> tb/sv/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Stimulus and verdict for the sorted priority queue.
// ----------------------------------------------------------------------------
// Runs a short directed sequence over the edge values, duplicates, misses,
// the unused command and a full queue, then random command mixes that swing
// the queue between empty and full. The sender idles in bursts, the receiver
// stalls on its own pattern with occasional long hold-offs. Checking is done
// by spq_checker.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam int unsigned RAND_ITEMS = 1650;
  localparam int unsigned IDLE_LIMIT = 2000;

  localparam int unsigned RX_FLOW   = 0;
  localparam int unsigned RX_LIGHT  = 1;
  localparam int unsigned RX_HEAVY  = 2;
  localparam int unsigned RX_TOGGLE = 3;
  localparam int unsigned RX_HOLD   = 4;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  spq_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  spq_out_t out_data_o;

  int unsigned fails;
  int unsigned pending;
  int unsigned checked;
  int unsigned drops;
  int unsigned hits;

  int unsigned        burst_left;
  int unsigned        cmd_count [4];
  logic signed [31:0] value_pool [8];

  sorted_priority_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  spq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked),
    .drops_o      (drops),
    .hits_o       (hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one command beat; a new burst may start with a gap
  task automatic issue(input logic [1:0] cmd, input logic signed [31:0] val);
    spq_in_t     beat;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    cmd_count[cmd]++;
    beat.command = cmd;
    beat.value   = val;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // mostly values from a small pool so removes and finds hit
  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    if (r < 65) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin : stimulus
    int unsigned ins_w;
    int unsigned rem_w;
    int unsigned r;
    logic [1:0]  cmd;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    burst_left  = 0;
    ins_w       = 50;
    rem_w       = 25;
    for (int k = 0; k < 4; k++) cmd_count[k] = 0;
    for (int k = 0; k < 8; k++) begin
      value_pool[k] = (k < 4) ? $signed($urandom_range(0, 20)) - 10 : $urandom;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, extremes, duplicates, misses, unused command
    issue(CMD_FIND, 32'sd0);
    issue(CMD_REMOVE, 32'sd0);
    issue(CMD_INSERT, 32'sh7fff_ffff);
    issue(CMD_INSERT, 32'sh8000_0000);
    issue(CMD_INSERT, 32'sd0);
    issue(CMD_INSERT, 32'sd0);
    issue(CMD_INSERT, -32'sd1);
    issue(CMD_FIND, 32'sd0);
    issue(CMD_FIND, 32'sd5);
    issue(CMD_UNUSED, 32'sh5555_aaaa);
    // fill to capacity, then one insert that must be refused
    for (int k = 0; k < 11; k++) issue(CMD_INSERT, k * 7 - 30);
    issue(CMD_INSERT, 32'sd42);
    issue(CMD_FIND, 32'sh7fff_ffff);
    issue(CMD_REMOVE, 32'sh8000_0000);
    issue(CMD_REMOVE, 32'sd0);
    issue(CMD_REMOVE, 32'sd12345);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // change the mix now and then so the queue fills and drains
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: begin ins_w = 65; rem_w = 15; end
          1: begin ins_w = 15; rem_w = 60; end
          default: begin ins_w = 40; rem_w = 35; end
        endcase
      end
      if ($urandom_range(0, 19) == 0) begin
        value_pool[$urandom_range(0, 7)] =
          $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 40)) - 20;
      end
      r = $urandom_range(0, 99);
      if (r < ins_w) cmd = CMD_INSERT;
      else if (r < ins_w + rem_w) cmd = CMD_REMOVE;
      else if (r < 95) cmd = CMD_FIND;
      else cmd = CMD_UNUSED;
      issue(cmd, pick_value());
    end
    in_valid_i <= 1'b0;

    // let the last beat reach the checker before looking at what is pending
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("sent %0d inserts, %0d removes, %0d finds, %0d unused commands",
             cmd_count[CMD_INSERT], cmd_count[CMD_REMOVE], cmd_count[CMD_FIND],
             cmd_count[CMD_UNUSED]);
    $display("checked %0d results: %0d inserts refused when full, %0d remove/find hits",
             checked, drops, hits);
    if (fails == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned seg;
    int unsigned len;
    int unsigned mode;
    out_stall_i <= 1'b0;
    seg = 0;
    wait (rst_ni === 1'b1);
    forever begin
      // an early long hold-off makes the queue back up into its input
      if (seg == 3 || $urandom_range(0, 15) == 0) mode = RX_HOLD;
      else mode = $urandom_range(RX_FLOW, RX_TOGGLE);
      len = (mode == RX_HOLD) ? $urandom_range(60, 150) : $urandom_range(10, 120);
      for (int c = 0; c < len; c++) begin
        @(posedge clk_i);
        case (mode)
          RX_FLOW:   out_stall_i <= 1'b0;
          RX_LIGHT:  out_stall_i <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:  out_stall_i <= ($urandom_range(0, 3) != 0);
          RX_TOGGLE: out_stall_i <= ~out_stall_i;
          default:   out_stall_i <= 1'b1;
        endcase
      end
      seg++;
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("no beat accepted for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
